/* src/rdz_pkg.sv */
package rdz_pkg;

  // Register map: index is the word address (paddr[2]).
  localparam logic REG_DEAD_ZONE = 1'b0;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int OUT_W = 16;
  localparam int Q_W = 17;
  localparam logic [OUT_W-2:0] OUT_MAX = 15'h7fff;
  localparam logic [15:0] TRIG_SCALE = 16'd257;

  // Stick pipeline depth in register stages, entry register to output register.
  function automatic int stick_latency(input int axis_w);
    return axis_w + 57;
  endfunction

endpackage

/* src/rdz_stick.sv */
module rdz_stick #(
  parameter int AXIS_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         adv,
  input  logic signed [AXIS_WIDTH-1:0] x_in,
  input  logic signed [AXIS_WIDTH-1:0] y_in,
  input  logic [2*AXIS_WIDTH+29:0]     dzf2,
  input  logic [AXIS_WIDTH+14:0]       dzf,
  input  logic [AXIS_WIDTH+14:0]       dd,
  output logic signed [rdz_pkg::OUT_W-1:0] x_out,
  output logic signed [rdz_pkg::OUT_W-1:0] y_out
);
  import rdz_pkg::*;

  localparam int AW = AXIS_WIDTH;
  localparam int RW = AW + 16;
  localparam int VW = 2 * AW + 32;
  localparam int SW = 2 * AW;
  localparam int DW = AW + 15;
  localparam int EW = AW + 17;
  localparam int PW = AW + 17;
  localparam int MW = AW + 34;
  localparam longint FSV = (64'sd1 <<< (AW - 1)) - 64'sd1;
  localparam logic [DW-1:0] LIM = DW'(FSV <<< 16);

  typedef struct packed {
    logic          live;
    logic          sx;
    logic          sy;
    logic [AW-1:0] ax;
    logic [AW-1:0] ay;
  } side_t;

  logic signed [AW-1:0] xa, ya;
  logic [SW-1:0] s;
  side_t sd;

  logic [RW:0]   srem  [0:RW];
  logic [RW-1:0] sroot [0:RW];
  logic [VW-1:0] srad  [0:RW];
  side_t         sside [0:RW];
  logic [RW+2:0] st    [1:RW];
  logic          sge   [1:RW];

  logic [DW-1:0] drem  [0:Q_W];
  logic [Q_W-1:0] dbits [0:Q_W];
  logic [Q_W-1:0] dq    [0:Q_W];
  logic [RW-1:0] dr    [0:Q_W];
  side_t         dside [0:Q_W];
  logic [DW:0]   dt    [1:Q_W];
  logic          dge   [1:Q_W];

  logic [PW-1:0] px, py;
  logic [RW-1:0] fr;
  side_t fside;

  logic [EW-1:0]  erx [0:Q_W];
  logic [EW-1:0]  ery [0:Q_W];
  logic [Q_W-1:0] ebx [0:Q_W];
  logic [Q_W-1:0] eby [0:Q_W];
  logic [Q_W-1:0] eqx [0:Q_W];
  logic [Q_W-1:0] eqy [0:Q_W];
  logic [RW-1:0]  er  [0:Q_W];
  side_t          eside [0:Q_W];
  logic [EW:0]    etx [1:Q_W];
  logic [EW:0]    ety [1:Q_W];
  logic           egx [1:Q_W];
  logic           egy [1:Q_W];

  logic [AW-1:0] abx, aby;
  logic [VW-1:0] v0;
  side_t c_side;
  logic [RW-1:0] rmin;
  logic [DW-1:0] n0;
  logic [MW-1:0] mx, my;

  function automatic logic [OUT_W-1:0] fmt(input logic [Q_W-1:0] q, input logic neg,
                                            input logic live);
    logic [OUT_W-2:0] mag;
    mag = (q > Q_W'(OUT_MAX)) ? OUT_MAX : q[OUT_W-2:0];
    if (!live) begin
      return '0;
    end
    return neg ? (OUT_W'(0) - {1'b0, mag}) : {1'b0, mag};
  endfunction

  always_comb begin
    abx = xa[AW-1] ? AW'(-xa) : AW'(xa);
    aby = ya[AW-1] ? AW'(-ya) : AW'(ya);
    v0 = {s, 32'd0};
    c_side = sd;
    c_side.live = v0 > {2'b00, dzf2};
    rmin = (sroot[RW] < {1'b0, LIM}) ? sroot[RW] : {1'b0, LIM};
    n0 = (rmin[DW-1:0] > dzf) ? rmin[DW-1:0] - dzf : '0;
    mx = MW'({px, 16'd0}) + MW'(fr);
    my = MW'({py, 16'd0}) + MW'(fr);
    for (int k = 1; k <= RW; k++) begin
      st[k] = {srem[k-1], srad[k-1][VW-1 -: 2]};
      sge[k] = st[k] >= {1'b0, sroot[k-1], 2'b01};
    end
    for (int k = 1; k <= Q_W; k++) begin
      dt[k] = {drem[k-1], dbits[k-1][Q_W-1]};
      dge[k] = dt[k] >= {1'b0, dd};
      etx[k] = {erx[k-1], ebx[k-1][Q_W-1]};
      ety[k] = {ery[k-1], eby[k-1][Q_W-1]};
      egx[k] = etx[k] >= {1'b0, er[k-1], 1'b0};
      egy[k] = ety[k] >= {1'b0, er[k-1], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xa <= x_in;
      ya <= y_in;
      s <= SW'(abx * abx) + SW'(aby * aby);
      sd <= '{live: 1'b0, sx: xa[AW-1], sy: ya[AW-1], ax: abx, ay: aby};

      // square root, one result bit per stage
      srem[0] <= '0;
      sroot[0] <= '0;
      srad[0] <= v0;
      sside[0] <= c_side;
      for (int k = 1; k <= RW; k++) begin
        if (sge[k]) begin
          srem[k] <= (RW+1)'(st[k] - {1'b0, sroot[k-1], 2'b01});
        end else begin
          srem[k] <= st[k][RW:0];
        end
        sroot[k] <= {sroot[k-1][RW-2:0], sge[k]};
        srad[k] <= srad[k-1] << 2;
        sside[k] <= sside[k-1];
      end

      // rescaled magnitude g = (N << 16) / D
      drem[0] <= {1'b0, n0[DW-1:1]};
      dbits[0] <= {n0[0], 16'd0};
      dq[0] <= '0;
      dr[0] <= sroot[RW];
      dside[0] <= sside[RW];
      for (int k = 1; k <= Q_W; k++) begin
        drem[k] <= dge[k] ? DW'(dt[k] - {1'b0, dd}) : dt[k][DW-1:0];
        dbits[k] <= dbits[k-1] << 1;
        dq[k] <= {dq[k-1][Q_W-2:0], dge[k]};
        dr[k] <= dr[k-1];
        dside[k] <= dside[k-1];
      end

      px <= PW'(dside[Q_W].ax * dq[Q_W]);
      py <= PW'(dside[Q_W].ay * dq[Q_W]);
      fr <= dr[Q_W];
      fside <= dside[Q_W];

      // per-axis rounding divide by 2R
      erx[0] <= mx[MW-1:Q_W];
      ery[0] <= my[MW-1:Q_W];
      ebx[0] <= mx[Q_W-1:0];
      eby[0] <= my[Q_W-1:0];
      eqx[0] <= '0;
      eqy[0] <= '0;
      er[0] <= fr;
      eside[0] <= fside;
      for (int k = 1; k <= Q_W; k++) begin
        erx[k] <= egx[k] ? EW'(etx[k] - {1'b0, er[k-1], 1'b0}) : etx[k][EW-1:0];
        ery[k] <= egy[k] ? EW'(ety[k] - {1'b0, er[k-1], 1'b0}) : ety[k][EW-1:0];
        ebx[k] <= ebx[k-1] << 1;
        eby[k] <= eby[k-1] << 1;
        eqx[k] <= {eqx[k-1][Q_W-2:0], egx[k]};
        eqy[k] <= {eqy[k-1][Q_W-2:0], egy[k]};
        er[k] <= er[k-1];
        eside[k] <= eside[k-1];
      end

      x_out <= fmt(eqx[Q_W], eside[Q_W].sx, eside[Q_W].live);
      y_out <= fmt(eqy[Q_W], eside[Q_W].sy, eside[Q_W].live);
    end
  end

endmodule

/* src/radial_deadzone_stick_conditioner.sv */
// Radial dead-zone conditioner for one gamepad report per transaction. Each stick
// vector is measured against full scale, zeroed inside the dead zone and rescaled
// outside it to Q1.15; triggers become Q0.16 (raw * 257); buttons pass through; a
// report with link_up low gives all zeros. While the output is not stalled the
// pipeline takes one transaction per clock through AXIS_WIDTH + 57 register
// stages, a depth set by the bit-per-stage square root and the two bit-per-stage
// dividers. When the output is stalled the whole pipeline holds. dead_zone sits
// at byte address 0; write it only while the pipeline is empty.
module radial_deadzone_stick_conditioner #(
  parameter int AXIS_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rdz_pkg::PADDR_W-1:0]     paddr,
  input  logic [rdz_pkg::PDATA_W-1:0]     pwdata,
  output logic [rdz_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [15:0]              left_x_raw,
  input  logic signed [15:0]              left_y_raw,
  input  logic signed [15:0]              right_x_raw,
  input  logic signed [15:0]              right_y_raw,
  input  logic [7:0]                      left_trigger_raw,
  input  logic [7:0]                      right_trigger_raw,
  input  logic [15:0]                     button_bits,
  input  logic                            link_up,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [15:0]              left_x_out,
  output logic signed [15:0]              left_y_out,
  output logic signed [15:0]              right_x_out,
  output logic signed [15:0]              right_y_out,
  output logic [15:0]                     left_trigger_out,
  output logic [15:0]                     right_trigger_out,
  output logic [15:0]                     buttons_out,
  output logic                            connected
);
  import rdz_pkg::*;

  localparam int AW = AXIS_WIDTH;
  localparam int L = stick_latency(AXIS_WIDTH);
  localparam int DW = AW + 15;
  localparam longint FSV = (64'sd1 <<< (AW - 1)) - 64'sd1;
  localparam logic [AW-2:0] FS = (AW-1)'(FSV);

  typedef struct packed {
    logic [15:0] lt;
    logic [15:0] rt;
    logic [15:0] btn;
    logic        conn;
  } side_t;

  logic [15:0] dead_zone;
  logic [DW-1:0] dzf;
  logic [2*AW+29:0] dzf2;
  logic [DW-1:0] dd;
  logic adv;
  logic cfg_wr;
  logic vld [0:L-1];
  side_t side [0:L-1];
  side_t side_in;
  logic signed [AW-1:0] lx, ly, rx, ry;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DEAD_ZONE);
  assign prdata = (paddr[2] == REG_DEAD_ZONE) ? {16'd0, dead_zone} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone <= '0;
    end else if (cfg_wr) begin
      dead_zone <= pwdata[15:0];
    end
  end

  // derived dead-zone terms: dzf and dd are registered from dead_zone, dzf2 from dzf
  always_ff @(posedge clk) begin
    dzf <= DW'(dead_zone * FS);
    dzf2 <= (2*AW+30)'(dzf * dzf);
    dd <= DW'(FS * (17'h10000 - {1'b0, dead_zone}));
  end

  assign adv = !vld[L-1] || out_ready;
  assign in_ready = adv;

  always_comb begin
    lx = link_up ? left_x_raw[AW-1:0] : '0;
    ly = link_up ? left_y_raw[AW-1:0] : '0;
    rx = link_up ? right_x_raw[AW-1:0] : '0;
    ry = link_up ? right_y_raw[AW-1:0] : '0;
    side_in.lt = link_up ? 16'({8'd0, left_trigger_raw} * TRIG_SCALE) : '0;
    side_in.rt = link_up ? 16'({8'd0, right_trigger_raw} * TRIG_SCALE) : '0;
    side_in.btn = link_up ? button_bits : '0;
    side_in.conn = link_up;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < L; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int k = 1; k < L; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= side_in;
      for (int k = 1; k < L; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  rdz_stick #(.AXIS_WIDTH(AXIS_WIDTH)) u_left (
    .clk(clk), .adv(adv), .x_in(lx), .y_in(ly),
    .dzf2(dzf2), .dzf(dzf), .dd(dd),
    .x_out(left_x_out), .y_out(left_y_out)
  );

  rdz_stick #(.AXIS_WIDTH(AXIS_WIDTH)) u_right (
    .clk(clk), .adv(adv), .x_in(rx), .y_in(ry),
    .dzf2(dzf2), .dzf(dzf), .dd(dd),
    .x_out(right_x_out), .y_out(right_y_out)
  );

  assign out_valid = vld[L-1];
  assign left_trigger_out = side[L-1].lt;
  assign right_trigger_out = side[L-1].rt;
  assign buttons_out = side[L-1].btn;
  assign connected = side[L-1].conn;

endmodule

/* bench/tb_radial_deadzone_stick_conditioner.sv */
`timescale 1ns / 100ps

module tb_radial_deadzone_stick_conditioner;
  import rdz_pkg::*;

  localparam int AXIS_W = 16;
  localparam int PIPE_LAT = AXIS_W + 57;
  localparam int WATCHDOG_MAX = 20000;
  localparam int N_RANDOM = 1800;
  localparam int HOLD_CYCLES = 300;
  localparam logic [PADDR_W-1:0] DZ_ADDR = PADDR_W'(REG_DEAD_ZONE) << 2;

  typedef struct packed {
    logic signed [15:0] lx, ly, rx, ry;
    logic [7:0] lt, rt;
    logic [15:0] btn;
    logic link;
  } report_t;

  typedef struct packed {
    logic signed [15:0] lx, ly, rx, ry;
    logic [15:0] lt, rt, btn;
    logic conn;
  } cond_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  report_t cur = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cond_t got;

  radial_deadzone_stick_conditioner #(.AXIS_WIDTH(AXIS_W)) u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .left_x_raw(cur.lx), .left_y_raw(cur.ly), .right_x_raw(cur.rx),
    .right_y_raw(cur.ry), .left_trigger_raw(cur.lt), .right_trigger_raw(cur.rt),
    .button_bits(cur.btn), .link_up(cur.link),
    .out_valid(out_valid), .out_ready(out_ready),
    .left_x_out(got.lx), .left_y_out(got.ly), .right_x_out(got.rx),
    .right_y_out(got.ry), .left_trigger_out(got.lt), .right_trigger_out(got.rt),
    .buttons_out(got.btn), .connected(got.conn)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  logic [15:0] dead_zone_q = '0;
  report_t pending_reports[$];
  cond_t expected_conds[$];
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;
  int send_gap = 0, recv_gap = 0;

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] shape_axis(input logic signed [15:0] c,
      input logic [63:0] g, input logic [63:0] r);
    logic [63:0] a, m;
    a = (c < 0) ? 64'(-int'(c)) : 64'(c);
    m = (2 * a * g * 32768 + r) / (2 * r);
    if (m > 32767) m = 32767;
    return (c < 0) ? -16'(m) : 16'(m);
  endfunction

  function automatic void shape_stick(input logic signed [15:0] x,
      input logic signed [15:0] y,
      output logic signed [15:0] ox, output logic signed [15:0] oy);
    logic [63:0] fs, s, dzf, r, n, d, g;
    fs = 32767;
    s = 64'(int'(x) * int'(x)) + 64'(int'(y) * int'(y));
    dzf = 64'(dead_zone_q) * fs;
    ox = 0;
    oy = 0;
    if ((s << 32) > dzf * dzf) begin
      r = isqrt(s << 32);
      if (r != 0) begin
        n = (r < (fs << 16)) ? r : (fs << 16);
        n = (n > dzf) ? n - dzf : 0;
        d = fs * (65536 - 64'(dead_zone_q));
        g = (n << 16) / d;
        ox = shape_axis(x, g, r);
        oy = shape_axis(y, g, r);
      end
    end
  endfunction

  function automatic cond_t condition_report(input report_t p);
    cond_t c;
    c = '0;
    if (p.link) begin
      shape_stick(p.lx, p.ly, c.lx, c.ly);
      shape_stick(p.rx, p.ry, c.rx, c.ry);
      c.lt = 16'(p.lt) * 16'd257;
      c.rt = 16'(p.rt) * 16'd257;
      c.btn = p.btn;
      c.conn = 1'b1;
    end
    return c;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_conds.push_back(condition_report(cur));
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_reports.size() > 0) begin
          cur <= pending_reports.pop_front();
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cond_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_conds.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          e = expected_conds.pop_front();
          if (got.lx !== e.lx) begin
            $error("left_x_out exp %0d got %0d", e.lx, got.lx); errors++;
          end
          if (got.ly !== e.ly) begin
            $error("left_y_out exp %0d got %0d", e.ly, got.ly); errors++;
          end
          if (got.rx !== e.rx) begin
            $error("right_x_out exp %0d got %0d", e.rx, got.rx); errors++;
          end
          if (got.ry !== e.ry) begin
            $error("right_y_out exp %0d got %0d", e.ry, got.ry); errors++;
          end
          if (got.lt !== e.lt) begin
            $error("left_trigger_out exp %0d got %0d", e.lt, got.lt); errors++;
          end
          if (got.rt !== e.rt) begin
            $error("right_trigger_out exp %0d got %0d", e.rt, got.rt); errors++;
          end
          if (got.btn !== e.btn) begin
            $error("buttons_out exp %0h got %0h", e.btn, got.btn); errors++;
          end
          if (got.conn !== e.conn) begin
            $error("connected exp %0d got %0d", e.conn, got.conn); errors++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        // hold off the output long enough to back the pipeline up
        hold_cnt <= HOLD_CYCLES;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 19);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst ||
        (pending_reports.size() == 0 && expected_conds.size() == 0 && !in_valid)) begin
      idle_cycles <= 0;
    end else if (hold_cnt == 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("tb_radial_deadzone_stick_conditioner: done, errors");
        $finish;
      end
    end
  end

  task automatic write_dead_zone(input logic [15:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= DZ_ADDR; pwdata <= PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    dead_zone_q = v;
  endtask

  task automatic drain;
    while (pending_reports.size() > 0 || in_valid || expected_conds.size() > 0)
      @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_axis();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(0, 600)) - 300);
      3: return 16'(int'($urandom_range(0, 8000)) - 4000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic report_t rand_report();
    report_t p;
    p.lx = pick_axis(); p.ly = pick_axis();
    p.rx = pick_axis(); p.ry = pick_axis();
    p.lt = 8'($urandom); p.rt = 8'($urandom);
    p.btn = 16'($urandom);
    p.link = ($urandom_range(0, 7) != 0);
    return p;
  endfunction

  task automatic add_report(input logic signed [15:0] lx, ly, rx, ry,
      input logic [7:0] lt, rt, input logic [15:0] btn, input logic link);
    report_t p;
    p.lx = lx; p.ly = ly; p.rx = rx; p.ry = ry;
    p.lt = lt; p.rt = rt; p.btn = btn; p.link = link;
    pending_reports.push_back(p);
  endtask

  task automatic run_random(input int n);
    repeat (n) pending_reports.push_back(rand_report());
  endtask

  initial begin
    logic [15:0] zones[6];
    zones = '{16'd0, 16'd65535, 16'd6554, 16'd32768, 16'd1, 16'd0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // directed: zero vector, full-scale corners, triggers, disconnected
    add_report(0, 0, 0, 0, 8'd0, 8'd0, 16'h0000, 1'b1);
    add_report(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 8'd255, 8'd255, 16'hffff, 1'b1);
    add_report(16'sh8000, 0, 0, 16'sh8000, 8'd1, 8'd128, 16'ha5a5, 1'b1);
    add_report(16'sh7fff, 0, 0, 16'sh7fff, 8'd254, 8'd0, 16'h5a5a, 1'b1);
    add_report(1, -1, -1, 1, 8'd0, 8'd255, 16'h0001, 1'b1);
    add_report(16'sh7fff, 16'sh8000, -5, 3, 8'd255, 8'd255, 16'hffff, 1'b0);
    add_report(23170, 23170, -23170, -23170, 8'd77, 8'd200, 16'h8000, 1'b1);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_dead_zone(zones[ph]);
      add_report(0, 0, 16'sh8000, 16'sh7fff, 8'd0, 8'd255, 16'h1234, 1'b1);
      add_report(100, -100, 2000, 2000, 8'd9, 8'd9, 16'h4321, 1'b1);
      if (ph == 1) begin
        hold_req = 1'b1;
        run_random(200);
        wait (hold_done && hold_cnt == 0);
        run_random(100);
      end else if (ph == 5) begin
        run_random(200);
        calm = 1'b1;
        drain();
        run_random(200);
      end else begin
        run_random(N_RANDOM / 6);
      end
      drain();
    end
    if (errors == 0) begin
      $display("tb_radial_deadzone_stick_conditioner: done, clean");
    end else begin
      $display("tb_radial_deadzone_stick_conditioner: done, errors");
    end
    $finish;
  end

endmodule
